// ----- rtl/bcas_pkg.sv -----
`default_nettype none

package bcas_pkg;

    localparam logic [1:0] OP_NEXT_MODE = 2'd0;
    localparam logic [1:0] OP_INCREMENT = 2'd1;
    localparam logic [1:0] OP_DECREMENT = 2'd2;
    localparam logic [1:0] OP_NO_KEY    = 2'd3;

    localparam logic [3:0] MODE_NONE      = 4'd0;
    localparam logic [3:0] MODE_SECONDS   = 4'd1;
    localparam logic [3:0] MODE_MINUTES   = 4'd2;
    localparam logic [3:0] MODE_HOURS     = 4'd3;
    localparam logic [3:0] MODE_DAY       = 4'd4;
    localparam logic [3:0] MODE_MONTH     = 4'd5;
    localparam logic [3:0] MODE_YEAR      = 4'd6;
    localparam logic [3:0] MODE_WEEKDAY   = 4'd7;
    localparam logic [3:0] MODE_AL_SECS   = 4'd8;
    localparam logic [3:0] MODE_AL_MINS   = 4'd9;
    localparam logic [3:0] MODE_AL_HOURS  = 4'd10;

    localparam logic [7:0] BCD_TOP_MIN_SEC = 8'h59;
    localparam logic [7:0] BCD_TOP_HOURS   = 8'h23;
    localparam logic [7:0] BCD_TOP_DAY     = 8'h31;
    localparam logic [7:0] BCD_TOP_MONTH   = 8'h12;
    localparam logic [7:0] BCD_TOP_YEAR    = 8'h99;
    localparam logic [7:0] TOP_WEEKDAY     = 8'h07;
    localparam logic [7:0] BOTTOM_ZERO     = 8'h00;
    localparam logic [7:0] BOTTOM_ONE      = 8'h01;
    localparam logic [3:0] DIGIT_OVER      = 4'hA;
    localparam logic [3:0] DIGIT_UNDER     = 4'hF;
    localparam logic [7:0] DIGIT_FIX       = 8'd6;

    typedef struct packed {
        logic [6:0] seconds;
        logic [6:0] minutes;
        logic [5:0] hours;
        logic [5:0] day;
        logic [4:0] month;
        logic [7:0] year;
        logic [2:0] weekday;
    } clk_fields_t;

    typedef struct packed {
        logic [7:0] seconds;
        logic [7:0] minutes;
        logic [7:0] hours;
    } alarm_t;

    function automatic logic [7:0] bcd_step(input logic up, input logic [7:0] v,
                                            input logic [7:0] bottom,
                                            input logic [7:0] top);
        logic [7:0] y;
        if (up) begin
            if (v == top) begin
                y = bottom;
            end else begin
                y = v + 8'd1;
                if (y[3:0] == DIGIT_OVER) begin
                    y = y + DIGIT_FIX;
                end
            end
        end else begin
            if (v == bottom) begin
                y = top;
            end else begin
                y = v - 8'd1;
                if (y[3:0] == DIGIT_UNDER) begin
                    y = y - DIGIT_FIX;
                end
            end
        end
        return y;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bcas_adjust.sv -----
`default_nettype none

module bcas_adjust (
    input  wire logic [1:0]           operation,
    input  wire logic [3:0]           mode,
    input  wire bcas_pkg::alarm_t      alarm,
    input  wire bcas_pkg::clk_fields_t cur,
    output logic [3:0]                mode_next,
    output bcas_pkg::alarm_t           alarm_next,
    output bcas_pkg::clk_fields_t      fields,
    output logic                      rtc_write,
    output logic                      alarm_hit
);

    logic       up;
    logic       key;
    logic [7:0] stepped;

    assign up  = (operation == bcas_pkg::OP_INCREMENT);
    assign key = (operation == bcas_pkg::OP_INCREMENT) ||
                 (operation == bcas_pkg::OP_DECREMENT);

    always_comb begin
        mode_next  = mode;
        alarm_next = alarm;
        fields     = cur;
        rtc_write  = 1'b0;
        stepped    = 8'd0;
        if (operation == bcas_pkg::OP_NEXT_MODE) begin
            mode_next = (mode < bcas_pkg::MODE_AL_HOURS) ? mode + 4'd1
                                                        : bcas_pkg::MODE_NONE;
        end else if (key) begin
            unique case (mode)
                bcas_pkg::MODE_SECONDS: begin
                    stepped = bcas_pkg::bcd_step(up, {1'b0, cur.seconds},
                        bcas_pkg::BOTTOM_ZERO, bcas_pkg::BCD_TOP_MIN_SEC);
                    fields.seconds = stepped[6:0];
                    rtc_write = 1'b1;
                end
                bcas_pkg::MODE_MINUTES: begin
                    stepped = bcas_pkg::bcd_step(up, {1'b0, cur.minutes},
                        bcas_pkg::BOTTOM_ZERO, bcas_pkg::BCD_TOP_MIN_SEC);
                    fields.minutes = stepped[6:0];
                    rtc_write = 1'b1;
                end
                bcas_pkg::MODE_HOURS: begin
                    stepped = bcas_pkg::bcd_step(up, {2'b0, cur.hours},
                        bcas_pkg::BOTTOM_ZERO, bcas_pkg::BCD_TOP_HOURS);
                    fields.hours = stepped[5:0];
                    rtc_write = 1'b1;
                end
                bcas_pkg::MODE_DAY: begin
                    stepped = bcas_pkg::bcd_step(up, {2'b0, cur.day},
                        bcas_pkg::BOTTOM_ONE, bcas_pkg::BCD_TOP_DAY);
                    fields.day = stepped[5:0];
                    rtc_write = 1'b1;
                end
                bcas_pkg::MODE_MONTH: begin
                    stepped = bcas_pkg::bcd_step(up, {3'b0, cur.month},
                        bcas_pkg::BOTTOM_ONE, bcas_pkg::BCD_TOP_MONTH);
                    fields.month = stepped[4:0];
                    rtc_write = 1'b1;
                end
                bcas_pkg::MODE_YEAR: begin
                    stepped = bcas_pkg::bcd_step(up, cur.year,
                        bcas_pkg::BOTTOM_ZERO, bcas_pkg::BCD_TOP_YEAR);
                    fields.year = stepped;
                    rtc_write = 1'b1;
                end
                bcas_pkg::MODE_WEEKDAY: begin
                    stepped = bcas_pkg::bcd_step(up, {5'b0, cur.weekday},
                        bcas_pkg::BOTTOM_ONE, bcas_pkg::TOP_WEEKDAY);
                    fields.weekday = stepped[2:0];
                    rtc_write = 1'b1;
                end
                bcas_pkg::MODE_AL_SECS: begin
                    stepped = bcas_pkg::bcd_step(up, alarm.seconds,
                        bcas_pkg::BOTTOM_ZERO, bcas_pkg::BCD_TOP_MIN_SEC);
                    alarm_next.seconds = stepped;
                end
                bcas_pkg::MODE_AL_MINS: begin
                    stepped = bcas_pkg::bcd_step(up, alarm.minutes,
                        bcas_pkg::BOTTOM_ZERO, bcas_pkg::BCD_TOP_MIN_SEC);
                    alarm_next.minutes = stepped;
                end
                bcas_pkg::MODE_AL_HOURS: begin
                    stepped = bcas_pkg::bcd_step(up, alarm.hours,
                        bcas_pkg::BOTTOM_ZERO, bcas_pkg::BCD_TOP_HOURS);
                    alarm_next.hours = stepped;
                end
                default: begin
                    stepped = 8'd0;
                end
            endcase
        end
    end

    assign alarm_hit = (alarm_next.hours   == {2'b0, fields.hours})   &&
                       (alarm_next.minutes == {1'b0, fields.minutes}) &&
                       (alarm_next.seconds == {1'b0, fields.seconds});

endmodule

`default_nettype wire

// ----- rtl/bcd_clock_alarm_setter.sv -----
// Clock and alarm setting controller for a BCD real-time clock.
// Each input transaction carries one key operation (next mode, increment,
// decrement or no key) together with the current clock fields read from
// the clock chip. Each input transaction produces exactly one output
// transaction: the adjust mode, the time fields after the adjustment, a
// write-back flag for the clock chip and an alarm-match flag.
// The block holds the adjust mode and the alarm hour, minute and second.
// An accepted transaction is captured in an input register and processed
// by the adjust logic into the result register, where the result becomes
// valid once the result register is free. One transaction can be accepted
// in every cycle while the receiver keeps m_ready high; the mode and alarm
// state advance as each transaction moves into the result register, so
// back-to-back keys see each other's effect.
// If the receiver holds m_ready low, the result register holds its value,
// the input register holds the next transaction, and s_ready drops once
// both are full. A synchronous active-low reset on aresetn clears both
// valid flags, sets the mode to none and the alarm time to 00:00:00.
`default_nettype none

module bcd_clock_alarm_setter (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_operation,
    input  wire logic [6:0] s_cur_seconds,
    input  wire logic [6:0] s_cur_minutes,
    input  wire logic [5:0] s_cur_hours,
    input  wire logic [5:0] s_cur_day,
    input  wire logic [4:0] s_cur_month,
    input  wire logic [7:0] s_cur_year,
    input  wire logic [2:0] s_cur_weekday,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [3:0]      m_mode_now,
    output logic [6:0]      m_new_seconds,
    output logic [6:0]      m_new_minutes,
    output logic [5:0]      m_new_hours,
    output logic [5:0]      m_new_day,
    output logic [4:0]      m_new_month,
    output logic [7:0]      m_new_year,
    output logic [2:0]      m_new_weekday,
    output logic            m_rtc_write,
    output logic            m_alarm_hit
);

    logic                  in_valid_reg;
    logic [1:0]            op_reg;
    bcas_pkg::clk_fields_t cur_reg;
    logic                  out_valid_reg;
    logic [3:0]            mode_out_reg;
    bcas_pkg::clk_fields_t fields_out_reg;
    logic                  write_out_reg;
    logic                  hit_out_reg;
    logic [3:0]            mode_reg;
    logic [3:0]            mode_next;
    bcas_pkg::alarm_t      alarm_reg;
    bcas_pkg::alarm_t      alarm_next;
    bcas_pkg::clk_fields_t fields_next;
    logic                  write_next;
    logic                  hit_next;
    logic                  out_free;
    logic                  advance;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    bcas_adjust u_adjust (
        .operation (op_reg),
        .mode      (mode_reg),
        .alarm     (alarm_reg),
        .cur       (cur_reg),
        .mode_next (mode_next),
        .alarm_next(alarm_next),
        .fields    (fields_next),
        .rtc_write (write_next),
        .alarm_hit (hit_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= bcas_pkg::MODE_NONE;
            alarm_reg     <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                alarm_reg     <= alarm_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg          <= s_operation;
            cur_reg.seconds <= s_cur_seconds;
            cur_reg.minutes <= s_cur_minutes;
            cur_reg.hours   <= s_cur_hours;
            cur_reg.day     <= s_cur_day;
            cur_reg.month   <= s_cur_month;
            cur_reg.year    <= s_cur_year;
            cur_reg.weekday <= s_cur_weekday;
        end
        if (advance) begin
            mode_out_reg   <= mode_next;
            fields_out_reg <= fields_next;
            write_out_reg  <= write_next;
            hit_out_reg    <= hit_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_mode_now    = mode_out_reg;
    assign m_new_seconds = fields_out_reg.seconds;
    assign m_new_minutes = fields_out_reg.minutes;
    assign m_new_hours   = fields_out_reg.hours;
    assign m_new_day     = fields_out_reg.day;
    assign m_new_month   = fields_out_reg.month;
    assign m_new_year    = fields_out_reg.year;
    assign m_new_weekday = fields_out_reg.weekday;
    assign m_rtc_write   = write_out_reg;
    assign m_alarm_hit   = hit_out_reg;

`ifndef SYNTHESIS
    a_mode_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg <= bcas_pkg::MODE_AL_HOURS)
        else $error("adjust mode out of range");

    a_write_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && write_out_reg |->
            (mode_out_reg >= bcas_pkg::MODE_SECONDS) &&
            (mode_out_reg <= bcas_pkg::MODE_WEEKDAY))
        else $error("write-back flagged outside a clock-setting mode");

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_ready |=> in_valid_reg && out_valid_reg)
        else $error("input register lost a transaction during a stall");

    a_alarm_hours: assert property (@(posedge aclk) disable iff (!aresetn)
        alarm_reg.hours <= bcas_pkg::BCD_TOP_HOURS)
        else $error("alarm hour left its range");
`endif

endmodule

`default_nettype wire
